@@ rtl/core/brbf_pkg.sv @@
// Shared types and defaults for the byte ring buffer FIFO core.
// Depends on nothing; brbf_index and the top level refer to it by scoped names.

package brbf_pkg;

   // Default number of slots in the circular store.
   localparam int DEPTH_DEFAULT = 256;

   // Request codes carried by one input beat.
   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_DISCARD = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   // Fill status reported with every result beat, already cut to the port width.
   typedef struct packed {
      logic [7:0] available;
      logic [7:0] contiguous;
      logic       wraps_more;
   } status_type;

endpackage

@@ rtl/core/brbf_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.

module brbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/core/brbf_index.sv @@
// Write and read index registers of the ring buffer, request decode and fill status.
// Depends on brbf_pkg.

module brbf_index #(
   parameter int DEPTH = brbf_pkg::DEPTH_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  brbf_pkg::op_type      op,
   input  logic [15:0]           count,
   output logic                  ok,
   output logic                  pop_hit,
   output logic                  ram_wr_en,
   output logic [AW-1:0]         ram_wr_addr,
   output logic                  ram_rd_en,
   output logic [AW-1:0]         ram_rd_addr,
   output brbf_pkg::status_type  status
);

   localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [AW-1:0] wr_next, rd_next;
   logic [AW-1:0] fill;
   logic [AW:0]   fill_w;
   logic [AW:0]   contig_w;
   logic [AW+15:0] cnt_ext;
   logic [AW+15:0] fill_ext;
   logic [AW-1:0] skip;
   logic [AW:0]   rd_sum;
   logic [AW-1:0] rd_disc;
   logic          full, empty;
   logic [AW+7:0] fill_wide;
   logic [AW+7:0] contig_wide;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
      next_slot = (i == LAST) ? '0 : i + AW'(1);
   endfunction

   // Occupancy and the run of unread bytes before the read index wraps.
   always_comb begin
      if (wr_ff >= rd_ff) begin
         fill_w   = {1'b0, wr_ff} - {1'b0, rd_ff};
         contig_w = fill_w;
      end else begin
         fill_w   = DEPTH_W - {1'b0, rd_ff} + {1'b0, wr_ff};
         contig_w = DEPTH_W - {1'b0, rd_ff};
      end
      fill = fill_w[AW-1:0];
   end

   assign wr_next = next_slot(wr_ff);
   assign rd_next = next_slot(rd_ff);
   assign full    = (wr_next == rd_ff);
   assign empty   = (wr_ff == rd_ff);

   // Discard count clamped to the bytes available, then added with wrap.
   always_comb begin
      cnt_ext  = {{AW{1'b0}}, count};
      fill_ext = {16'b0, fill};
      skip     = (cnt_ext > fill_ext) ? fill : cnt_ext[AW-1:0];
      rd_sum   = {1'b0, rd_ff} + {1'b0, skip};
      if (rd_sum >= DEPTH_W) begin
         rd_sum = rd_sum - DEPTH_W;
      end
      rd_disc = rd_sum[AW-1:0];
   end

   // Request decode: index updates and store accesses.
   always_comb begin
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      ok        = 1'b1;
      pop_hit   = 1'b0;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      case (op)
         brbf_pkg::OP_PUSH: begin
            ok = !full;
            if (accept && !full) begin
               ram_wr_en = 1'b1;
               wr_in     = wr_next;
            end
         end
         brbf_pkg::OP_POP: begin
            ok      = !empty;
            pop_hit = !empty;
            if (accept && !empty) begin
               ram_rd_en = 1'b1;
               rd_in     = rd_next;
            end
         end
         brbf_pkg::OP_DISCARD: begin
            if (accept) begin
               rd_in = rd_disc;
            end
         end
         brbf_pkg::OP_CLEAR: begin
            if (accept) begin
               wr_in = '0;
               rd_in = '0;
            end
         end
         default: begin
            ok = 1'b1;
         end
      endcase
   end

   assign ram_wr_addr = wr_ff;
   assign ram_rd_addr = rd_ff;

   // Status of the current indices, cut to the 8-bit result fields.
   always_comb begin
      fill_wide         = {8'b0, fill};
      contig_wide       = {8'b0, contig_w[AW-1:0]};
      status.available  = fill_wide[7:0];
      status.contiguous = contig_wide[7:0];
      status.wraps_more = (wr_ff < rd_ff);
   end

   // Index registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   // A successful push grows the occupancy by exactly one byte.
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && op == brbf_pkg::OP_PUSH && !full) |=> (fill == $past(fill) + AW'(1)))
      else $error("push did not grow occupancy by one");

   // A clear leaves both indices at zero.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && op == brbf_pkg::OP_CLEAR) |=> (wr_ff == '0 && rd_ff == '0))
      else $error("clear did not zero the indices");

   // Both indices stay inside the store.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ff <= LAST && rd_ff <= LAST))
      else $error("index beyond the last slot");

   // Occupancy never exceeds one less than the depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_w <= DEPTH_W - (AW+1)'(1)))
      else $error("occupancy beyond capacity");

endmodule

@@ rtl/core/byte_ring_buffer_fifo_core.sv @@
// Top level of the byte ring buffer FIFO core: request handshake, result register, store.
// Depends on brbf_pkg, brbf_ram and brbf_index.

// A byte FIFO in a circular store of DEPTH slots holding at most DEPTH-1 bytes. Each
// request beat (push, pop, discard or clear) yields exactly one result beat with the
// success flag, the popped byte and the fill status after the request. A request is
// accepted every cycle while results are taken. Its result beat passes through stage
// one, where the store's registered read is issued at acceptance, and then into the
// result register, which loads when stage one moves on. The rate is set by the index
// registers, which update at the accepting edge so the next request sees them at once.
// The store has no reset; contents survive a clear.

module byte_ring_buffer_fifo_core #(
   parameter int DEPTH = brbf_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_data_in,
   input  logic [15:0] req_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [7:0]  rsp_data_out,
   output logic [7:0]  rsp_available,
   output logic [7:0]  rsp_contiguous,
   output logic        rsp_wraps_more
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                 accept;
   logic                 ok;
   logic                 pop_hit;
   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [7:0]           ram_rd_data;
   brbf_pkg::status_type status;

   logic s1_valid_ff, s1_valid_in;
   logic s1_ok_ff, s1_pop_ff;
   logic s1_move;
   logic out_valid_ff, out_valid_in;
   logic out_ok_ff;
   logic [7:0] out_data_ff;
   brbf_pkg::status_type out_status_ff;

   // Stage one moves on when the result register is free or being emptied.
   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   brbf_index #(
      .DEPTH(DEPTH)
   ) u_index (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (brbf_pkg::op_type'(req_op)),
      .count       (req_count),
      .ok          (ok),
      .pop_hit     (pop_hit),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .status      (status)
   );

   brbf_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (req_data_in),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // Control state of the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: stage one keeps the outcome while the store read completes; the index
   // registers still hold this beat's post-request state when it moves on.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ok_ff  <= ok;
         s1_pop_ff <= pop_hit;
      end
      if (s1_move) begin
         out_ok_ff     <= s1_ok_ff;
         out_data_ff   <= s1_pop_ff ? ram_rd_data : 8'd0;
         out_status_ff <= status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ok         = out_ok_ff;
   assign rsp_data_out   = out_data_ff;
   assign rsp_available  = out_status_ff.available;
   assign rsp_contiguous = out_status_ff.contiguous;
   assign rsp_wraps_more = out_status_ff.wraps_more;

   // A stalled result with stage one occupied blocks new requests.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && s1_valid_ff) |-> !req_ready)
      else $error("request taken while both stages are full");

   // A result beat only appears after a beat passed through stage one.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a staged request");

   // A store read is only issued for an accepted pop.
   a_read_on_pop: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (accept && req_op == brbf_pkg::OP_POP))
      else $error("store read outside an accepted pop");

endmodule
